@@ rtl/core/gimv_pkg.sv @@
package gimv_pkg;

	localparam int MAX_LENGTH = 4096;
	localparam int MAX_ROWS   = 65536;

	localparam int POS_W  = $clog2(MAX_LENGTH);
	localparam int LEN_W  = POS_W + 1;
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int RC_W   = ROW_W + 1;
	localparam int CNT_W  = $clog2(POS_W);
	localparam int CFG_W  = 17;
	localparam int CIDX_W = 2;

	localparam logic [1:0] FUNC_ACT    = 2'd0;
	localparam logic [1:0] FUNC_SCALE  = 2'd1;
	localparam logic [1:0] FUNC_WEIGHT = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_LEN  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_GS   = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_ROWS = 2'd2;

	localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(MAX_LENGTH);
	localparam logic [LEN_W-1:0] GS_RESET   = LEN_W'(32);
	localparam logic [RC_W-1:0]  ROWS_RESET = RC_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_MAC,
		ST_MUL1,
		ST_MUL2,
		ST_ADD
	} state_t;

	typedef struct packed {
		logic wr_act;
		logic wr_scale;
		logic cap_weight;
		logic mem_read;
		logic div_start;
		logic div_step;
		logic mac;
		logic mul1;
		logic mul2;
		logic add;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic dirty;
		logic div_done;
		logic grp_end;
	} sts_t;

endpackage

@@ rtl/core/grouped_int8_matvec_top.sv @@
// Channel   Handshake                 Payload
// request   start / busy              func, load_index, act_value, act_scale,
//                                     weight_value, weight_scale
// result    row_strobe (one cycle)    row_value, row_index, last_row
// config    cfg_we                    cfg_index, cfg_data
//
// Activation loads, scale loads and unused function codes are taken while idle and leave busy low.
// A weight request reads the activation store and then accumulates; when it
// closes a group it goes on through the two scale multiply stages and the add.
// The first weight request after a configuration write first runs the serial
// divider that locates the position within its group.
// Reset clears the control state only; the two stores hold no values until
// loaded, and there is no clearing pass. The receiver cannot stall results.
module grouped_int8_matvec_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [11:0]                   load_index,
	input  logic signed [7:0]             act_value,
	input  logic signed [31:0]            act_scale,
	input  logic signed [7:0]             weight_value,
	input  logic signed [31:0]            weight_scale,
	input  logic                          cfg_we,
	input  logic [gimv_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [gimv_pkg::CFG_W-1:0]    cfg_data,
	output logic                          row_strobe,
	output logic signed [63:0]            row_value,
	output logic [15:0]                   row_index,
	output logic                          last_row
);

	gimv_pkg::cmd_t cmd;
	gimv_pkg::sts_t sts;

	gimv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	gimv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.load_index   (load_index),
		.act_value    (act_value),
		.act_scale    (act_scale),
		.weight_value (weight_value),
		.weight_scale (weight_scale),
		.row_value    (row_value),
		.row_index    (row_index),
		.last_row     (last_row),
		.row_strobe   (row_strobe)
	);

endmodule

@@ rtl/core/gimv_ctrl.sv @@
module gimv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        func,
	input  gimv_pkg::sts_t    sts,
	output gimv_pkg::cmd_t    cmd,
	output logic              busy
);

	gimv_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gimv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != gimv_pkg::ST_IDLE);
		unique case (state_q)
			gimv_pkg::ST_IDLE: begin
				if (start) begin
					unique case (func)
						gimv_pkg::FUNC_ACT:   cmd.wr_act = 1'b1;
						gimv_pkg::FUNC_SCALE: cmd.wr_scale = 1'b1;
						gimv_pkg::FUNC_WEIGHT: begin
							cmd.cap_weight = 1'b1;
							if (sts.dirty) begin
								cmd.div_start = 1'b1;
								state_d = gimv_pkg::ST_DIV;
							end else begin
								cmd.mem_read = 1'b1;
								state_d = gimv_pkg::ST_MAC;
							end
						end
						default: ;
					endcase
				end
			end
			gimv_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = gimv_pkg::ST_READ;
				end
			end
			gimv_pkg::ST_READ: begin
				cmd.mem_read = 1'b1;
				state_d = gimv_pkg::ST_MAC;
			end
			gimv_pkg::ST_MAC: begin
				cmd.mac = 1'b1;
				if (sts.grp_end) begin
					state_d = gimv_pkg::ST_MUL1;
				end else begin
					cmd.advance = 1'b1;
					state_d = gimv_pkg::ST_IDLE;
				end
			end
			gimv_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = gimv_pkg::ST_MUL2;
			end
			gimv_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = gimv_pkg::ST_ADD;
			end
			gimv_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				cmd.advance = 1'b1;
				state_d = gimv_pkg::ST_IDLE;
			end
			default: state_d = gimv_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/gimv_dp.sv @@
module gimv_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gimv_pkg::cmd_t                cmd,
	output gimv_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [gimv_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [gimv_pkg::CFG_W-1:0]    cfg_data,
	input  logic [11:0]                   load_index,
	input  logic signed [7:0]             act_value,
	input  logic signed [31:0]            act_scale,
	input  logic signed [7:0]             weight_value,
	input  logic signed [31:0]            weight_scale,
	output logic signed [63:0]            row_value,
	output logic [15:0]                   row_index,
	output logic                          last_row,
	output logic                          row_strobe
);

	localparam int PW = gimv_pkg::POS_W;
	localparam int LW = gimv_pkg::LEN_W;
	localparam int RW = gimv_pkg::ROW_W;
	localparam int CW = gimv_pkg::RC_W;
	localparam int CNT_WL = gimv_pkg::CNT_W;

	logic signed [7:0]  act_mem [gimv_pkg::MAX_LENGTH];
	logic signed [31:0] scl_mem [gimv_pkg::MAX_LENGTH];

	logic [LW-1:0] len_q, gs_q;
	logic [CW-1:0] rc_q;
	logic          dirty_q;

	logic [PW-1:0] pos_q, off_q, grp_q;
	logic signed [31:0] gacc_q, held_ws_q;
	logic signed [63:0] row_acc_q;
	logic [RW-1:0] row_cnt_q;

	logic signed [7:0]  w_q;
	logic signed [31:0] ws_q;
	logic signed [7:0]  act_rd_q;
	logic signed [31:0] scl_rd_q;

	logic [PW-1:0]    div_num_q, div_rem_q;
	logic [CNT_WL-1:0] div_cnt_q;

	logic signed [63:0] sp_q;
	logic signed [63:0] phi_q;
	logic signed [64:0] plo_q;

	logic signed [63:0] out_value_q;
	logic [RW-1:0]      out_index_q;
	logic               out_last_q, strobe_q;

	logic [PW-1:0] pos_c;
	logic          row_end, grp_end, last_c;
	logic [PW:0]   rem_shift;
	logic          qbit;
	logic [PW-1:0] rem_next;
	logic signed [31:0] dot;
	logic signed [15:0] prod;
	logic signed [63:0] term, sum, sat_sum;

	function automatic logic [LW-1:0] clamp_len(input logic [gimv_pkg::CFG_W-1:0] v);
		logic [LW-1:0] r;
		if (v[LW-1:0] == '0) begin
			r = LW'(1);
		end else if (v[LW-1:0] > LW'(gimv_pkg::MAX_LENGTH)) begin
			r = LW'(gimv_pkg::MAX_LENGTH);
		end else begin
			r = v[LW-1:0];
		end
		return r;
	endfunction

	always_comb begin
		if ({1'b0, pos_q} >= len_q) begin
			pos_c = PW'(len_q - LW'(1));
		end else begin
			pos_c = pos_q;
		end
		row_end = ({1'b0, pos_c} == (len_q - LW'(1)));
		grp_end = ({1'b0, off_q} == (gs_q - LW'(1))) || row_end;
		last_c  = ({1'b0, row_cnt_q} == (rc_q - CW'(1)));

		rem_shift = {div_rem_q, div_num_q[PW-1]};
		qbit      = ({1'b0, rem_shift} >= {1'b0, gs_q});
		rem_next  = qbit ? PW'(rem_shift - (PW+1)'(gs_q)) : rem_shift[PW-1:0];

		prod = act_rd_q * w_q;
		dot  = ((off_q == '0) ? 32'sd0 : gacc_q) + 32'(prod);

		term = phi_q + 64'($signed(plo_q[64:32]));
		sum  = row_acc_q + term;
		if ((row_acc_q[63] == term[63]) && (sum[63] != term[63])) begin
			sat_sum = term[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_sum = sum;
		end

		sts.dirty    = dirty_q;
		sts.div_done = (div_cnt_q == CNT_WL'(PW - 1));
		sts.grp_end  = grp_end;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_act) begin
			act_mem[load_index] <= act_value;
		end
		if (cmd.wr_scale) begin
			scl_mem[load_index] <= act_scale;
		end
		if (cmd.mem_read) begin
			act_rd_q <= act_mem[pos_c];
			scl_rd_q <= scl_mem[grp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= gimv_pkg::LEN_RESET;
			gs_q  <= gimv_pkg::GS_RESET;
			rc_q  <= gimv_pkg::ROWS_RESET;
			dirty_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dirty_q <= 1'b1;
				unique case (cfg_index)
					gimv_pkg::CFG_LEN: len_q <= clamp_len(cfg_data);
					gimv_pkg::CFG_GS:  gs_q  <= clamp_len(cfg_data);
					gimv_pkg::CFG_ROWS: begin
						if (cfg_data == '0) begin
							rc_q <= CW'(1);
						end else if (cfg_data[CW-1:0] > CW'(gimv_pkg::MAX_ROWS)) begin
							rc_q <= CW'(gimv_pkg::MAX_ROWS);
						end else begin
							rc_q <= cfg_data[CW-1:0];
						end
					end
					default: ;
				endcase
			end else if (cmd.div_step && sts.div_done) begin
				dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_weight) begin
			w_q  <= weight_value;
			ws_q <= weight_scale;
		end
		if (cmd.div_start) begin
			div_num_q <= pos_c;
			div_rem_q <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_num_q <= {div_num_q[PW-2:0], qbit};
			div_rem_q <= rem_next;
			div_cnt_q <= div_cnt_q + CNT_WL'(1);
		end
		if (cmd.mul1) begin
			sp_q <= held_ws_q * scl_rd_q;
		end
		if (cmd.mul2) begin
			phi_q <= $signed(sp_q[63:32]) * gacc_q;
			plo_q <= $signed({1'b0, sp_q[31:0]}) * gacc_q;
		end
		if (cmd.add && row_end) begin
			out_value_q <= sat_sum;
			out_index_q <= row_cnt_q;
			out_last_q  <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			off_q     <= '0;
			grp_q     <= '0;
			gacc_q    <= '0;
			held_ws_q <= '0;
			row_acc_q <= '0;
			row_cnt_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cmd.add && row_end;
			if (cmd.div_step && sts.div_done) begin
				off_q <= rem_next;
				grp_q <= {div_num_q[PW-2:0], qbit};
			end
			if (cmd.mac) begin
				gacc_q <= dot;
				if (off_q == '0) begin
					held_ws_q <= ws_q;
				end
			end
			if (cmd.add && !row_end) begin
				row_acc_q <= sat_sum;
			end
			if (cmd.advance) begin
				if (row_end) begin
					pos_q     <= '0;
					off_q     <= '0;
					grp_q     <= '0;
					gacc_q    <= '0;
					row_acc_q <= '0;
					row_cnt_q <= last_c ? '0 : row_cnt_q + RW'(1);
				end else begin
					pos_q <= pos_c + PW'(1);
					if ({1'b0, off_q} == (gs_q - LW'(1))) begin
						off_q <= '0;
						grp_q <= grp_q + PW'(1);
					end else begin
						off_q <= off_q + PW'(1);
					end
				end
			end
		end
	end

	assign row_value  = out_value_q;
	assign row_index  = out_index_q;
	assign last_row   = out_last_q;
	assign row_strobe = strobe_q;

endmodule

@@ rtl/core/gimv_checker.sv @@
module gimv_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [1:0]                    func,
	input logic                          row_strobe
);

	// A weight request taken while idle always raises busy.
	a_weight_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == gimv_pkg::FUNC_WEIGHT) |=> busy)
		else $error("weight request did not raise busy");

	// Loads and unused codes finish in the cycle they are taken.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func != gimv_pkg::FUNC_WEIGHT) |=> !busy)
		else $error("load request held the block busy");

	// A result appears only once the block has gone back to idle.
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		row_strobe |-> !busy)
		else $error("result shown while busy");

	// Each result closes a group, so strobes never follow each other.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		row_strobe |=> !row_strobe)
		else $error("back to back result strobes");

	// A result is always caused by a weight request in a previous cycle.
	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		row_strobe |-> $past(busy))
		else $error("result without a request in flight");

endmodule

bind grouped_int8_matvec_top gimv_checker u_gimv_checker (.*);
